// ===== rtl/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Line text match counter package
// Shared types and constants for the line matcher and its window cells.
// ----------------------------------------------------------------------------
package lmc_pkg;

  localparam int QUERY_SLOTS = 16;

  typedef logic [QUERY_SLOTS-1:0][7:0] lmc_query_t;

  typedef struct packed {
    logic ok_next;
    logic ok_skip0;
    logic ok_skip1;
  } lmc_cell_flags_t;

  typedef enum logic [1:0] {
    MODE_PREFIX   = 2'd0,
    MODE_CONTAINS = 2'd1,
    MODE_SUFFIX   = 2'd2
  } lmc_mode_t;

  typedef enum logic [2:0] {
    REG_QUERY_LOW  = 3'd0,
    REG_QUERY_HIGH = 3'd1,
    REG_QUERY_LEN  = 3'd2,
    REG_MODE       = 3'd3,
    REG_HEAD_LIMIT = 3'd4,
    REG_COUNT_MODE = 3'd5
  } lmc_reg_t;

  localparam logic        ACT_BYTE   = 1'b0;
  localparam logic        ACT_END    = 1'b1;
  localparam logic [7:0]  BYTE_NL    = 8'h0A;
  localparam logic [7:0]  BYTE_CR    = 8'h0D;
  localparam logic [30:0] ANSWER_MAX = 31'h7FFF_FFFF;
  localparam logic [4:0]  LEN_MAX    = 5'd31;

endpackage

// ===== rtl/line_text_match_counter.sv =====
// ----------------------------------------------------------------------------
// Line text match counter
// Tests each line of a byte stream against a query and reports the first
// matching line number or the number of matching lines.
// ----------------------------------------------------------------------------
// Usage:
// The in_ channel carries one item per transfer: tuser low means tdata[7:0]
// is a text byte, tuser high marks end of text. A newline ends a line.
// The cfg_ channel writes the registers by index; cfg_ready is always high.
// Write them between texts or between bytes, never with a result pending.
// Text bytes are taken at one per cycle, back to back; the 17-cell window
// chain compares every byte against the query in the cycle it arrives.
// The end-of-text transfer yields one result on the out_ channel, valid in
// the next cycle, answer in tdata[30:0]. The block then starts a new text.
// While a result waits on a stalled receiver, text bytes are still taken;
// only a further end-of-text transfer waits until the result is taken.
// Reset clears the line and answer state (not the window cells) and restores the register reset values.
// ----------------------------------------------------------------------------
module line_text_match_counter #(
  parameter int MAX_QUERY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // answer[30:0], zero[31]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lmc_pkg::*;

  localparam int DEPTH = MAX_QUERY + 1;

  logic [63:0] query_low_r;
  logic [63:0] query_high_r;
  logic [4:0]  key_len_r;
  logic [1:0]  mode_r;
  logic [30:0] head_limit_r;
  logic        count_mode_r;

  logic [4:0]  row_len_r,   row_len_nxt;
  logic        alive_r,     alive_nxt;
  logic        seen_r,      seen_nxt;
  logic        hit_r,       hit_nxt;
  logic [30:0] line_num_r,  line_num_nxt;
  logic [30:0] answer_r,    answer_nxt;
  logic        done_r,      done_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_data_r,  out_data_nxt;

  lmc_query_t      query;
  logic [4:0]      qlen;
  logic [7:0]      win [DEPTH];
  lmc_cell_flags_t cflags [DEPTH];
  logic [DEPTH-1:0] ok_next, ok_skip0, ok_skip1;

  logic        accept, is_byte, is_nl, take, is_end, finish, strip;
  logic [4:0]  row_len_inc, content;
  logic [30:0] ln_inc, ans_fin;
  logic        head_ok, line_match, done_fin;

  assign query     = lmc_query_t'({query_high_r, query_low_r});
  assign qlen      = (key_len_r > 5'(MAX_QUERY)) ? 5'(MAX_QUERY) : key_len_r;
  assign cfg_ready = 1'b1;

  assign in_tready  = !out_valid_r || out_tready || (in_tuser == ACT_BYTE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  assign accept  = in_tvalid && in_tready;
  assign is_byte = accept && (in_tuser == ACT_BYTE);
  assign is_nl   = is_byte && (in_tdata == BYTE_NL);
  assign take    = is_byte && !is_nl;
  assign is_end  = accept && (in_tuser == ACT_END);

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    lmc_cell #(.INDEX(j)) u_cell (
      .clk      (clk),
      .shift_en (take),
      .data_in  ((j == 0) ? in_tdata : win[(j == 0) ? 0 : j - 1]),
      .query    (query),
      .qlen     (qlen),
      .data_out (win[j]),
      .flags    (cflags[j])
    );
    assign ok_next[j]  = cflags[j].ok_next;
    assign ok_skip0[j] = cflags[j].ok_skip0;
    assign ok_skip1[j] = cflags[j].ok_skip1;
  end

  assign finish      = is_nl || (is_end && (row_len_r != 5'd0));
  assign strip       = is_nl && (row_len_r >= 5'd2) && (win[0] == BYTE_CR);
  assign content     = strip ? (row_len_r - 5'd1) : row_len_r;
  assign row_len_inc = (row_len_r != LEN_MAX) ? (row_len_r + 5'd1) : row_len_r;
  assign ln_inc      = (line_num_r != ANSWER_MAX) ? (line_num_r + 31'd1) : line_num_r;
  assign head_ok     = (head_limit_r == 31'd0) || (ln_inc <= head_limit_r);

  always_comb begin
    case (mode_r)
      MODE_PREFIX:   line_match = (content >= qlen) && alive_r;
      MODE_CONTAINS: line_match = strip ? seen_r : (seen_r || hit_r);
      MODE_SUFFIX:   line_match = (content >= qlen) && (strip ? (&ok_skip1) : (&ok_skip0));
      default:       line_match = 1'b0;
    endcase
  end

  always_comb begin
    ans_fin  = answer_r;
    done_fin = done_r;
    if (finish && !done_r && head_ok && line_match) begin
      if (count_mode_r) begin
        if (answer_r != ANSWER_MAX) begin
          ans_fin = answer_r + 31'd1;
        end
      end else begin
        ans_fin  = ln_inc;
        done_fin = 1'b1;
      end
    end
  end

  always_comb begin
    row_len_nxt   = row_len_r;
    alive_nxt     = alive_r;
    seen_nxt      = seen_r;
    hit_nxt       = hit_r;
    line_num_nxt  = line_num_r;
    answer_nxt    = ans_fin;
    done_nxt      = done_fin;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (take) begin
      if ((row_len_r < qlen) && (in_tdata != query[row_len_r[3:0]])) begin
        alive_nxt = 1'b0;
      end
      row_len_nxt = row_len_inc;
      seen_nxt    = seen_r || hit_r;
      hit_nxt     = (row_len_inc >= qlen) && (&ok_next);
    end
    if (finish) begin
      line_num_nxt = ln_inc;
      row_len_nxt  = 5'd0;
      alive_nxt    = 1'b1;
      seen_nxt     = 1'b0;
      hit_nxt      = 1'b0;
    end
    if (is_end) begin
      row_len_nxt   = 5'd0;
      alive_nxt     = 1'b1;
      seen_nxt      = 1'b0;
      hit_nxt       = 1'b0;
      line_num_nxt  = 31'd0;
      answer_nxt    = 31'd0;
      done_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = (qlen == 5'd0) ? 31'd0 : ans_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_low_r  <= '0;
      query_high_r <= '0;
      key_len_r    <= '0;
      mode_r       <= MODE_CONTAINS;
      head_limit_r <= '0;
      count_mode_r <= 1'b0;
      row_len_r    <= '0;
      alive_r      <= 1'b1;
      seen_r       <= 1'b0;
      hit_r        <= 1'b0;
      line_num_r   <= '0;
      answer_r     <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUERY_LOW:  query_low_r  <= cfg_data;
          REG_QUERY_HIGH: query_high_r <= cfg_data;
          REG_QUERY_LEN:  key_len_r    <= cfg_data[4:0];
          REG_MODE:       mode_r       <= cfg_data[1:0];
          REG_HEAD_LIMIT: head_limit_r <= cfg_data[30:0];
          REG_COUNT_MODE: count_mode_r <= cfg_data[0];
          default: ;
        endcase
      end
      row_len_r   <= row_len_nxt;
      alive_r     <= alive_nxt;
      seen_r      <= seen_nxt;
      hit_r       <= hit_nxt;
      line_num_r  <= line_num_nxt;
      answer_r    <= answer_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/lmc_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one text byte of the recent-byte window, passes it to its neighbor
// on every text byte other than a newline, and compares the bytes it sees against the query.
// ----------------------------------------------------------------------------
module lmc_cell #(
  parameter int INDEX = 0
) (
  input  logic                   clk,
  input  logic                   shift_en,
  input  logic [7:0]             data_in,
  input  lmc_pkg::lmc_query_t    query,
  input  logic [4:0]             qlen,
  output logic [7:0]             data_out,
  output lmc_pkg::lmc_cell_flags_t flags
);
  import lmc_pkg::*;

  localparam logic [4:0] IDX = 5'(INDEX);

  logic [7:0] byte_r;
  logic [4:0] sel0;
  logic [4:0] sel1;
  logic       in0;
  logic       in1;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= data_in;
    end
  end

  assign data_out = byte_r;
  assign sel0     = qlen - 5'd1 - IDX;
  assign sel1     = qlen - IDX;
  assign in0      = IDX < qlen;
  assign in1      = (IDX != 5'd0) && (IDX <= qlen);

  assign flags.ok_next  = !in0 || (data_in == query[sel0[3:0]]);
  assign flags.ok_skip0 = !in0 || (byte_r == query[sel0[3:0]]);
  assign flags.ok_skip1 = !in1 || (byte_r == query[sel1[3:0]]);

endmodule

// ===== rtl/lmc_checker.sv =====
// ----------------------------------------------------------------------------
// Line text match counter checker
// Port-level checks on result timing and output register behavior.
// ----------------------------------------------------------------------------
module lmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import lmc_pkg::*;

  logic end_xfer;
  assign end_xfer = in_tvalid && in_tready && (in_tuser == ACT_END);

  a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    end_xfer |=> out_tvalid)
    else $error("No result after end-of-text transfer.");

  a_result_only_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(end_xfer))
    else $error("Result appeared without end-of-text transfer.");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    end_xfer |-> (!out_tvalid || out_tready))
    else $error("End-of-text taken while a result was stalled.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("Stalled result changed.");

endmodule

bind line_text_match_counter lmc_checker u_lmc_checker (.*);

// ===== tb/sv/line_match_answer_checker.sv =====
// ----------------------------------------------------------------------------
// Line match answer checker
// Watches the register, text and answer channels of the line text match
// counter. It keeps its own copy of the registers and of the per-line match
// state, works out the answer for every end-of-text transfer and compares
// each answer transfer with the oldest answer still due.
// ----------------------------------------------------------------------------
module line_match_answer_checker
  import lmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  lmc_query_t  query;
  logic [4:0]  key_len;
  logic [1:0]  match_mode;
  logic [30:0] head_lim;
  logic        tally_lines;

  logic [7:0]  recent [QUERY_SLOTS+1];
  logic [4:0]  row_len;
  logic        prefix_ok;
  logic        seen_inside;
  logic        hit_last;
  logic [30:0] line_no;
  logic [30:0] tally;
  logic        found;

  logic [30:0] answers_due [$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int active_len();
    return (key_len > QUERY_SLOTS) ? QUERY_SLOTS : int'(key_len);
  endfunction

  function automatic bit tail_equals(input int skip, input int qlen);
    int i;
    int k;
    for (i = 0; i < qlen; i++) begin
      k = skip + qlen - 1 - i;
      if (k > QUERY_SLOTS || recent[k] != query[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_line();
    row_len     = '0;
    prefix_ok   = 1'b1;
    seen_inside = 1'b0;
    hit_last    = 1'b0;
  endfunction

  function automatic void clear_text();
    foreach (recent[i]) recent[i] = '0;
    clear_line();
    line_no = '0;
    tally   = '0;
    found   = 1'b0;
  endfunction

  function automatic bit line_hits(input bit strip);
    int qlen;
    int content;
    qlen    = active_len();
    content = strip ? int'(row_len) - 1 : int'(row_len);
    case (match_mode)
      MODE_PREFIX:   return content >= qlen && prefix_ok;
      MODE_CONTAINS: return strip ? seen_inside : (seen_inside || hit_last);
      MODE_SUFFIX:   return content >= qlen && tail_equals(strip ? 1 : 0, qlen);
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void close_line(input bit strip);
    if (line_no != ANSWER_MAX) line_no++;
    if (!found && !(head_lim != 0 && line_no > head_lim) && line_hits(strip)) begin
      if (tally_lines) begin
        if (tally != ANSWER_MAX) tally++;
      end else begin
        tally = line_no;
        found = 1'b1;
      end
    end
    clear_line();
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    int qlen;
    qlen = active_len();
    if (int'(row_len) < qlen && b != query[row_len[3:0]]) prefix_ok = 1'b0;
    for (int i = QUERY_SLOTS; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b;
    if (row_len != LEN_MAX) row_len++;
    if (hit_last) seen_inside = 1'b1;
    hit_last = int'(row_len) >= qlen && tail_equals(0, qlen);
  endfunction

  function automatic logic [30:0] finish_text();
    logic [30:0] ans;
    if (row_len != 0) close_line(1'b0);
    ans = (active_len() == 0) ? '0 : tally;
    clear_text();
    return ans;
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_QUERY_LOW:  query[7:0]  = val;
      REG_QUERY_HIGH: query[15:8] = val;
      REG_QUERY_LEN:  key_len     = val[4:0];
      REG_MODE:       match_mode  = val[1:0];
      REG_HEAD_LIMIT: head_lim    = val[30:0];
      REG_COUNT_MODE: tally_lines = val[0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      query       = '0;
      key_len     = '0;
      match_mode  = MODE_CONTAINS;
      head_lim    = '0;
      tally_lines = 1'b0;
      clear_text();
      answers_due.delete();
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("answer transfer 0x%08h with no answer due", out_tdata));
        end else begin
          if (out_tdata !== {1'b0, answers_due[0]})
            report_mismatch($sformatf("answer field 0x%08h, expected %0d",
                                      out_tdata, answers_due[0]));
          void'(answers_due.pop_front());
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        if (in_tuser == ACT_END) answers_due.push_back(finish_text());
        else if (in_tdata == BYTE_NL) close_line(row_len >= 2 && recent[0] == BYTE_CR);
        else take_byte(in_tdata);
      end
      pending <= answers_due.size();
    end
  end

endmodule

// ===== tb/sv/line_text_match_counter_test.sv =====
// ----------------------------------------------------------------------------
// Line text match counter test
// Drives texts and register settings into the line text match counter:
// a short directed set for the line ending and query corner cases, then
// random texts under changing settings with random idling on both sides and
// one long receiver hold-off. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module line_text_match_counter_test;
  import lmc_pkg::*;

  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         HOLD_CYCLES   = 200;
  localparam int         ITEM_TARGET   = 640;
  localparam int         REG_INDEX_TOP = (1 << $bits(lmc_reg_t)) - 1;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = ACT_BYTE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [63:0] cfg_data   = '0;

  int fail_count;
  int pending;
  int checked;

  int items_sent  = 0;
  int texts       = 0;
  int writes      = 0;
  int held_cycles = 0;
  int cycle_count = 0;
  bit hold_req    = 1'b0;
  bit calm        = 1'b0;

  lmc_query_t cur_query = '0;
  logic [4:0] cur_qlen  = '0;

  line_text_match_counter dut (.*);

  line_match_answer_checker checker_i (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          @(negedge clk);
          held_cycles++;
        end
        out_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    writes++;
  endtask

  function automatic logic [7:0] text_symbol();
    case ($urandom_range(0, 7))
      0, 1:    return 8'h61;
      2:       return 8'h62;
      3:       return 8'h00;
      4:       return BYTE_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 1) == 0) return cur_query[$urandom_range(0, QUERY_SLOTS - 1)];
    return text_symbol();
  endfunction

  task automatic send_filler(input int n);
    repeat (n) send_item(ACT_BYTE, filler_byte());
  endtask

  task automatic random_line(input bit terminate);
    int kind;
    int qeff;
    int i;
    qeff = (cur_qlen > QUERY_SLOTS) ? QUERY_SLOTS : int'(cur_qlen);
    kind = $urandom_range(0, 5);
    if (kind == 1 || kind == 2) send_filler($urandom_range(0, 4));
    if (kind <= 2) begin
      for (i = 0; i < qeff; i++)
        send_item(ACT_BYTE, ($urandom_range(0, 15) == 0) ? filler_byte() : cur_query[i]);
    end
    if (kind <= 1) send_filler($urandom_range(0, 4));
    if (kind == 3) send_filler($urandom_range(0, 12));
    if (kind == 4) send_filler($urandom_range(28, 40));
    if ($urandom_range(0, 3) == 0) send_item(ACT_BYTE, BYTE_CR);
    if (terminate) send_item(ACT_BYTE, BYTE_NL);
  endtask

  task automatic random_text();
    int lines;
    int k;
    lines = $urandom_range(1, 4);
    for (k = 0; k < lines; k++) begin
      if (k > 0 && $urandom_range(0, 11) == 0) begin
        settle();
        write_reg(REG_MODE, 64'($urandom_range(0, 3)));
      end
      random_line(k < lines - 1 || $urandom_range(0, 3) != 0);
    end
    send_item(ACT_END, 8'($urandom_range(0, 255)));
    texts++;
  endtask

  task automatic random_setup();
    logic [63:0] word;
    int i;
    settle();
    for (i = 0; i < QUERY_SLOTS; i++) cur_query[i] = text_symbol();
    if ($urandom_range(0, 3) == 0) cur_query[7:0] = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) cur_query[15:8] = {$urandom, $urandom};
    write_reg(REG_QUERY_LOW, cur_query[7:0]);
    write_reg(REG_QUERY_HIGH, cur_query[15:8]);
    case ($urandom_range(0, 7))
      0:       word = '0;
      1:       word = 64'(QUERY_SLOTS);
      2:       word = 64'($urandom_range(QUERY_SLOTS + 1, LEN_MAX));
      3:       word = {$urandom, $urandom};
      default: word = 64'($urandom_range(1, 4));
    endcase
    cur_qlen = word[4:0];
    write_reg(REG_QUERY_LEN, word);
    write_reg(REG_MODE, 64'($urandom_range(0, 3)));
    case ($urandom_range(0, 5))
      0:       word = 64'(ANSWER_MAX);
      1:       word = {$urandom, $urandom};
      2, 3:    word = 64'($urandom_range(1, 4));
      default: word = '0;
    endcase
    write_reg(REG_HEAD_LIMIT, word);
    write_reg(REG_COUNT_MODE, 64'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      write_reg(3'($urandom_range(int'(REG_COUNT_MODE) + 1, REG_INDEX_TOP)),
                {$urandom, $urandom});
  endtask

  initial begin : stimulus
    int phase_left;
    bit pressed;
    phase_left = 0;
    pressed    = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Suffix count with a zero query byte, return stripping, a lone return
    // line and an unterminated last line beyond the head limit.
    write_reg(REG_QUERY_LEN, 64'd1);
    write_reg(REG_MODE, 64'(MODE_SUFFIX));
    write_reg(REG_COUNT_MODE, 64'd1);
    write_reg(REG_HEAD_LIMIT, 64'd3);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, BYTE_CR);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_BYTE, BYTE_CR);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_END, 8'hFF);
    texts++;

    // Contains, first match, an oversized query length, and a length change
    // in the middle of a text.
    settle();
    write_reg(REG_QUERY_LEN, 64'(LEN_MAX));
    write_reg(REG_MODE, 64'(MODE_CONTAINS));
    write_reg(REG_COUNT_MODE, 64'd0);
    write_reg(REG_HEAD_LIMIT, 64'd0);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, BYTE_NL);
    settle();
    write_reg(REG_QUERY_LEN, 64'd1);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_END, 8'h00);
    texts++;

    // The unused mode, an unknown register index, and an empty query.
    settle();
    write_reg(REG_MODE, 64'(MODE_UNUSED));
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_END, 8'h00);
    texts++;
    settle();
    write_reg(3'($urandom_range(int'(REG_COUNT_MODE) + 1, REG_INDEX_TOP)),
              {$urandom, $urandom});
    write_reg(REG_QUERY_LEN, 64'd0);
    write_reg(REG_MODE, 64'(MODE_PREFIX));
    send_item(ACT_BYTE, BYTE_NL);
    send_item(ACT_END, 8'hA5);
    texts++;

    while (items_sent < ITEM_TARGET) begin
      if (phase_left == 0) begin
        random_setup();
        phase_left = $urandom_range(2, 6);
      end
      if (!pressed && items_sent >= 300) begin
        settle();
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (5) begin
          send_item(ACT_BYTE, cur_query[0]);
          send_item(ACT_BYTE, BYTE_NL);
          send_item(ACT_END, 8'($urandom_range(0, 255)));
          texts++;
        end
        calm    = 1'b0;
        pressed = 1'b1;
      end
      if (items_sent >= ITEM_TARGET - 75) calm = 1'b1;
      random_text();
      phase_left--;
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Ran %0d texts in %0d input transfers under %0d register writes; %0d answers compared.",
             texts, items_sent, writes, checked);
    $display("The answer side was held off for %0d cycles while text kept coming.",
             held_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lmc_pkg.sv
rtl/lmc_cell.sv
rtl/line_text_match_counter.sv
rtl/lmc_checker.sv
tb/sv/line_match_answer_checker.sv
tb/sv/line_text_match_counter_test.sv
